>>> rtl/core/sound_level_meter_alarm_defines.svh
// Assertion macros shared by the sound level meter RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef SOUND_LEVEL_METER_ALARM_DEFINES_SVH
`define SOUND_LEVEL_METER_ALARM_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SLMA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slma assertion failed");

// Next-cycle implication, disabled during reset
`define SLMA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slma assertion failed");

`endif

>>> rtl/core/slma_pkg.sv
// Shared types, constants and the log2 table of the sound level meter.
// No dependencies.
`timescale 1ns / 1ps
package slma_pkg;

  localparam int SMOOTH_FRAC_BITS_DEF = 8;

  localparam int LEVEL_W    = 11;
  localparam int RMS_W      = 16;
  localparam int SUM_W      = 43;
  localparam int CNT_W      = 32;
  localparam int RUN_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [14:0]        RMS_MAX   = 15'd32767;
  localparam logic [9:0]         FLOOR_X10 = 10'd903;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 11'd1200;
  localparam logic [RUN_W-1:0]   RUN_MAX   = 8'd255;

  localparam logic [6:0] THR_LOW   = 7'd30;
  localparam logic [6:0] THR_HIGH  = 7'd120;
  localparam logic [6:0] THR_RESET = 7'd85;
  localparam logic [10:0] OFFSET_RESET = 11'd1000;
  localparam logic [4:0]  HYST_RESET   = 5'd3;
  localparam logic [7:0]  ENTER_RESET  = 8'd3;
  localparam logic [7:0]  EXIT_RESET   = 8'd10;
  localparam logic [3:0]  RISE_RESET   = 4'd3;
  localparam logic [3:0]  FALL_RESET   = 4'd5;

  // dB scale 60206/65536000, halved so the denominator is 2^15 * 1000
  localparam int SCALE_NUM   = 60206;
  localparam int SCALE_DEN   = 65536000;
  localparam int PRE_SHIFT   = 15;
  localparam logic [14:0] SCALE_MUL = 15'(SCALE_NUM / 2);
  localparam logic [34:0] SCALE_RND = 35'(SCALE_DEN / 4);
  localparam logic [9:0]  DIV_K     = 10'(SCALE_DEN / 2 / (2 ** PRE_SHIFT));
  // Reciprocal of DIV_K, rounded down: quotient is exact or one low
  localparam logic [10:0] RECIP     = 11'd1048;
  localparam logic [19:0] LG_FULL   = 20'(15 * 65536);

  // Q16 log2(1 + k/16), k = 0..16
  localparam logic [16:0] LOG2_TAB [17] = '{
    17'd0,     17'd5732,  17'd11136, 17'd16248, 17'd21098, 17'd25711,
    17'd30109, 17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472,
    17'd52911, 17'd56229, 17'd59434, 17'd62534, 17'd65536
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_OFFSET    = 3'd1,
    CFG_HYST      = 3'd2,
    CFG_ENTER     = 3'd3,
    CFG_EXIT      = 3'd4,
    CFG_RISE      = 3'd5,
    CFG_FALL      = 3'd6
  } slma_cfg_idx_t;

  typedef struct packed {
    logic [6:0]  alarm_level_db;
    logic [10:0] level_offset_x10;
    logic [4:0]  hysteresis_db;
    logic [7:0]  enter_frames;
    logic [7:0]  exit_frames;
    logic [3:0]  rise_shift;
    logic [3:0]  fall_shift;
  } slma_cfg_t;

  typedef struct packed {
    logic             mode;
    logic [RMS_W-1:0] rms_level;
  } slma_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_db_x10;
    logic [LEVEL_W-1:0] smooth_db_x10;
    logic [LEVEL_W-1:0] peak_hold_x10;
    logic [SUM_W-1:0]   level_sum;
    logic [CNT_W-1:0]   frame_count;
    logic               alarm_on;
    logic               alarm_toggled;
    logic [CNT_W-1:0]   alarm_total;
  } slma_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOG,
    ST_SCALE,
    ST_DIV,
    ST_FIX,
    ST_UPD
  } slma_state_t;

  typedef struct packed {
    logic load_in;
    logic step_log;
    logic step_scale;
    logic step_div;
    logic step_fix;
    logic commit;
  } slma_cmd_t;

  typedef struct packed {
    logic in_mode;
  } slma_sts_t;

endpackage

>>> rtl/core/sound_level_meter_alarm.sv
// Sound level meter with hysteresis alarm, top level.
// Depends on slma_pkg, slma_cfg, slma_ctrl and slma_datapath.
//
// Usage:
//  Input channel (in_valid / in_stall / in_data) takes one word per frame:
//  mode 0 measures rms_level, mode 1 clears the session statistics.
//  Result channel (out_valid / out_stall / out_data) returns one word for
//  every input word, in order.
//  Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//  one register per cycle; cfg_ready is high out of reset. Write only while idle.
//  A measuring word steps through the five-step sequencer (log lookup, scale
//  multiply, reciprocal multiply, quotient fix, update) before it shows on
//  out_valid; a session clear goes straight to the update step. A session
//  clear can be taken every cycle while out_stall does not hold the result.
//  A new word is taken in the cycle its predecessor commits to the output
//  register. While out_stall holds, the held result stays and the next
//  word waits in its update step.
//  Reset (rst_n low, synchronous) loads register defaults, clears the
//  smoother, statistics and alarm, drops out_valid and holds in_stall high.
`timescale 1ns / 1ps
module sound_level_meter_alarm import slma_pkg::*; #(
  parameter int SMOOTH_FRAC_BITS = SMOOTH_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  slma_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output slma_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  slma_cfg_t cfg;
  slma_cmd_t cmd;
  slma_sts_t sts;

  // Register file
  slma_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer
  slma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and meter state
  slma_datapath #(
    .SMOOTH_FRAC_BITS (SMOOTH_FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg      (cfg),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

>>> rtl/core/slma_cfg.sv
// Configuration register file with threshold range check.
// Depends on slma_pkg.
`timescale 1ns / 1ps
module slma_cfg import slma_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output slma_cfg_t             cfg
);

  slma_cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = rst_n;
  assign cfg      = cfg_r;

  // Decode the write; load default threshold when out of range
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (slma_cfg_idx_t'(cfg_index))
        CFG_THRESHOLD: begin
          if (cfg_data[6:0] < THR_LOW || cfg_data[6:0] > THR_HIGH) begin
            cfg_nxt.alarm_level_db = THR_RESET;
          end else begin
            cfg_nxt.alarm_level_db = cfg_data[6:0];
          end
        end
        CFG_OFFSET: cfg_nxt.level_offset_x10 = cfg_data[10:0];
        CFG_HYST:   cfg_nxt.hysteresis_db    = cfg_data[4:0];
        CFG_ENTER:  cfg_nxt.enter_frames     = cfg_data[7:0];
        CFG_EXIT:   cfg_nxt.exit_frames      = cfg_data[7:0];
        CFG_RISE:   cfg_nxt.rise_shift       = cfg_data[3:0];
        CFG_FALL:   cfg_nxt.fall_shift       = cfg_data[3:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alarm_level_db   <= THR_RESET;
      cfg_r.level_offset_x10 <= OFFSET_RESET;
      cfg_r.hysteresis_db    <= HYST_RESET;
      cfg_r.enter_frames     <= ENTER_RESET;
      cfg_r.exit_frames      <= EXIT_RESET;
      cfg_r.rise_shift       <= RISE_RESET;
      cfg_r.fall_shift       <= FALL_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> rtl/core/slma_ctrl.sv
// Sequencer: steps one word through log, scale, divide, fix and update; a session clear goes straight to update.
// Depends on slma_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sound_level_meter_alarm_defines.svh"
module slma_ctrl import slma_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  slma_sts_t sts,
  output slma_cmd_t cmd
);

  slma_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        commit;
  logic        accept;

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    commit   = (state_r == ST_UPD) && (!out_valid_r || !out_stall);
    in_stall = !rst_n || !((state_r == ST_IDLE) || commit);
    accept   = in_valid && !in_stall;

    cmd            = '0;
    cmd.load_in    = accept;
    cmd.step_log   = (state_r == ST_LOG);
    cmd.step_scale = (state_r == ST_SCALE);
    cmd.step_div   = (state_r == ST_DIV);
    cmd.step_fix   = (state_r == ST_FIX);
    cmd.commit     = commit;

    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = sts.in_mode ? ST_UPD : ST_LOG;
        end
      end
      ST_LOG:   state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_DIV;
      ST_DIV:   state_nxt = ST_FIX;
      ST_FIX:   state_nxt = ST_UPD;
      ST_UPD: begin
        if (commit) begin
          if (accept) begin
            state_nxt = sts.in_mode ? ST_UPD : ST_LOG;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // Hold the result until taken; a commit refills the slot
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  `SLMA_ASSERT_NEXT(a_commit_fills, commit, out_valid_r)
  `SLMA_ASSERT_IMPL(a_accept_state, !in_stall, (state_r == ST_IDLE) || (state_r == ST_UPD))
  `SLMA_ASSERT_NEXT(a_log_to_scale, state_r == ST_LOG, state_r == ST_SCALE)

endmodule

>>> rtl/core/slma_datapath.sv
// Datapath: log2 conversion, dB scaling, smoother, statistics and alarm.
// Depends on slma_pkg; driven by slma_ctrl commands.
`timescale 1ns / 1ps
module slma_datapath import slma_pkg::*; #(
  parameter int SMOOTH_FRAC_BITS = SMOOTH_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  slma_in_t  in_data,
  input  slma_cfg_t cfg,
  input  slma_cmd_t cmd,
  output slma_sts_t sts,
  output slma_out_t out_data
);

  localparam int SW = LEVEL_W + SMOOTH_FRAC_BITS;
  localparam int MW = SW + 16;
  localparam logic [SW:0] HALF = (SW + 1)'((2 ** SMOOTH_FRAC_BITS) >> 1);

  // Payload registers
  slma_in_t           in_r;
  logic [19:0]        base_r;
  logic [12:0]        interp_r;
  logic               zero_r;
  logic [19:0]        t_r;
  logic [9:0]         q0_r;
  logic [LEVEL_W-1:0] db_r;
  slma_out_t          out_r;

  // Meter state
  logic [SW-1:0]      smoothed_r, smoothed_nxt;
  logic               primed_r, primed_nxt;
  logic [LEVEL_W-1:0] last_r, last_nxt;
  logic [LEVEL_W-1:0] peak_r, peak_nxt;
  logic [SUM_W-1:0]   total_r, total_nxt;
  logic [CNT_W-1:0]   frames_r, frames_nxt;
  logic [RUN_W-1:0]   above_r, above_nxt;
  logic [RUN_W-1:0]   below_r, below_nxt;
  logic               alarm_r, alarm_nxt;
  logic [CNT_W-1:0]   entries_r, entries_nxt;
  logic               toggled;

  assign sts.in_mode = in_data.mode;
  assign out_data    = out_r;

  // Log step: leading one, table lookup, interpolation product
  logic [14:0] r15;
  logic [3:0]  n;
  logic [31:0] shifted;
  logic [15:0] frac;
  logic [16:0] lo, hi;
  logic [12:0] span;
  logic [24:0] prod;
  logic [19:0] base;

  always_comb begin
    r15 = in_r.rms_level[15] ? RMS_MAX : in_r.rms_level[14:0];
    n = 4'd0;
    for (int i = 1; i < 15; i++) begin
      if (r15[i]) begin
        n = 4'(i);
      end
    end
    shifted = 32'(r15) << (5'd16 - {1'b0, n});
    frac    = shifted[15:0];
    lo      = LOG2_TAB[{1'b0, frac[15:12]}];
    hi      = LOG2_TAB[{1'b0, frac[15:12]} + 5'd1];
    span    = 13'(hi - lo);
    prod    = 25'(span) * 25'(frac[11:0]);
    base    = {n, 16'd0} + {3'd0, lo};
  end

  // Scale step: distance below full scale times the dB factor
  logic [19:0] lg;
  logic [19:0] below_full;
  logic [34:0] scaled;

  always_comb begin
    lg         = base_r + 20'(interp_r);
    below_full = LG_FULL - lg;
    scaled     = 35'(SCALE_MUL) * 35'(below_full) + SCALE_RND;
  end

  // Divide step: reciprocal estimate of t / DIV_K
  logic [30:0] qprod;
  assign qprod = 31'(t_r) * 31'(RECIP);

  // Fix step: correct the quotient, add offset, clamp
  logic [19:0] qchk;
  logic [19:0] qrem;
  logic [9:0]  q;
  logic [12:0] lvl;
  logic [LEVEL_W-1:0] db;

  always_comb begin
    qchk = 20'(q0_r) * 20'(DIV_K);
    qrem = t_r - qchk;
    q    = (qrem >= 20'(DIV_K)) ? q0_r + 10'd1 : q0_r;
    if (zero_r) begin
      q = FLOOR_X10;
    end
    lvl = {2'd0, cfg.level_offset_x10} - {3'd0, q};
    if (lvl[12]) begin
      db = '0;
    end else if (lvl[11:0] > 12'(LEVEL_MAX)) begin
      db = LEVEL_MAX;
    end else begin
      db = lvl[LEVEL_W-1:0];
    end
  end

  // Update step: smoother, statistics, alarm
  logic [SW-1:0]  target;
  logic [MW-1:0]  fall_mag;
  logic [MW-1:0]  fall_step;
  logic [SW-1:0]  rise_step;
  logic [10:0]    thr;
  logic [8:0]     hyst10;
  logic [10:0]    rel;
  logic           rel_ok;
  logic [SW:0]    rounded;

  always_comb begin
    target    = SW'(db_r) << SMOOTH_FRAC_BITS;
    rise_step = (target - smoothed_r) >> cfg.rise_shift;
    fall_mag  = MW'(smoothed_r - target);
    fall_step = (fall_mag + ((MW'(1) << cfg.fall_shift) - MW'(1))) >> cfg.fall_shift;
    thr       = 11'(cfg.alarm_level_db) * 11'd10;
    hyst10    = 9'(cfg.hysteresis_db) * 9'd10;
    rel_ok    = (11'(hyst10) <= thr);
    rel       = thr - 11'(hyst10);

    smoothed_nxt = smoothed_r;
    primed_nxt   = primed_r;
    last_nxt     = last_r;
    peak_nxt     = peak_r;
    total_nxt    = total_r;
    frames_nxt   = frames_r;
    above_nxt    = above_r;
    below_nxt    = below_r;
    alarm_nxt    = alarm_r;
    entries_nxt  = entries_r;
    toggled      = 1'b0;

    if (in_r.mode) begin
      // Clear session statistics, keep smoother and alarm
      last_nxt    = '0;
      peak_nxt    = '0;
      total_nxt   = '0;
      frames_nxt  = '0;
      above_nxt   = '0;
      below_nxt   = '0;
      entries_nxt = '0;
    end else begin
      last_nxt = db_r;
      if (!primed_r) begin
        smoothed_nxt = target;
        primed_nxt   = 1'b1;
      end else if (target > smoothed_r) begin
        smoothed_nxt = smoothed_r + rise_step;
      end else begin
        smoothed_nxt = smoothed_r - SW'(fall_step);
      end
      frames_nxt = frames_r + CNT_W'(1);
      total_nxt  = total_r + SUM_W'(db_r);
      if (db_r > peak_r) begin
        peak_nxt = db_r;
      end

      // Run counters, saturating
      if (db_r >= thr) begin
        above_nxt = (above_r < RUN_MAX) ? above_r + RUN_W'(1) : above_r;
        below_nxt = '0;
      end else if (rel_ok && db_r <= rel) begin
        below_nxt = (below_r < RUN_MAX) ? below_r + RUN_W'(1) : below_r;
        above_nxt = '0;
      end else begin
        above_nxt = '0;
        below_nxt = '0;
      end

      // Hysteresis alarm
      if (!alarm_r && above_nxt >= cfg.enter_frames) begin
        alarm_nxt   = 1'b1;
        entries_nxt = entries_r + CNT_W'(1);
      end else if (alarm_r && below_nxt >= cfg.exit_frames) begin
        alarm_nxt = 1'b0;
      end
      toggled = (alarm_nxt != alarm_r);
    end

    rounded = ({1'b0, smoothed_nxt} + HALF) >> SMOOTH_FRAC_BITS;
  end

  // Payload pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.step_log) begin
      base_r   <= base;
      interp_r <= prod[24:12];
      zero_r   <= (in_r.rms_level == '0);
    end
    if (cmd.step_scale) begin
      t_r <= scaled[34:PRE_SHIFT];
    end
    if (cmd.step_div) begin
      q0_r <= qprod[29:20];
    end
    if (cmd.step_fix) begin
      db_r <= db;
    end
    if (cmd.commit) begin
      out_r.level_db_x10  <= last_nxt;
      out_r.smooth_db_x10 <= rounded[LEVEL_W-1:0];
      out_r.peak_hold_x10 <= peak_nxt;
      out_r.level_sum     <= total_nxt;
      out_r.frame_count   <= frames_nxt;
      out_r.alarm_on      <= alarm_nxt;
      out_r.alarm_toggled <= toggled;
      out_r.alarm_total   <= entries_nxt;
    end
  end

  // Meter state, advanced on commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smoothed_r <= '0;
      primed_r   <= 1'b0;
      last_r     <= '0;
      peak_r     <= '0;
      total_r    <= '0;
      frames_r   <= '0;
      above_r    <= '0;
      below_r    <= '0;
      alarm_r    <= 1'b0;
      entries_r  <= '0;
    end else if (cmd.commit) begin
      smoothed_r <= smoothed_nxt;
      primed_r   <= primed_nxt;
      last_r     <= last_nxt;
      peak_r     <= peak_nxt;
      total_r    <= total_nxt;
      frames_r   <= frames_nxt;
      above_r    <= above_nxt;
      below_r    <= below_nxt;
      alarm_r    <= alarm_nxt;
      entries_r  <= entries_nxt;
    end
  end

endmodule
